### rtl/hrlq_pkg.sv
package hrlq_pkg;

    // character codes
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_QM    = 8'h3F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_DIG0  = 8'h30;
    localparam logic [7:0] CH_DIG9  = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;

    localparam int KEY_BYTES = 16;
    localparam int KEY_LEN_W = 5;
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_MAX = KEY_LEN_W'(KEY_BYTES);
    localparam logic [KEY_LEN_W-1:0] KEY_POS_SAT = '1;

    // result slots per byte: held CR or CRLF done, current byte, held CR at buffer end, done
    localparam int SLOTS  = 4;
    localparam int SLOT_W = $clog2(SLOTS);

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_PATH,
        PH_QKEY,
        PH_QVAL,
        PH_TAIL
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_END,
        KIND_DONE
    } kind_t;

    typedef enum logic [1:0] {
        TAG_METHOD,
        TAG_PATH,
        TAG_KEY,
        TAG_VALUE
    } tag_t;

    typedef enum logic [1:0] {
        REG_KEY_LOW,
        REG_KEY_HIGH,
        REG_KEY_LEN
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_HIGH,
        ESC_LOW
    } esc_t;

    typedef struct packed {
        kind_t      kind;
        tag_t       tag;
        logic [7:0] data;
        logic       bad;
        logic       nov;
        logic       match;
        logic       status;
    } res_t;

    typedef struct packed {
        phase_t                 phase;
        logic                   cr;
        esc_t                   esc;
        logic [3:0]             hi;
        logic                   inv;
        logic                   tok_eq;
        logic [KEY_LEN_W-1:0]   key_pos;
        logic                   key_diff;
        logic                   done;
    } st_t;

    typedef struct packed {
        res_t [SLOTS-1:0] res;
        logic [SLOTS-1:0] mask;
    } qent_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

### rtl/hrlq_in_if.sv
interface hrlq_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_buffer;

    modport source (output valid, output in_byte, output end_of_buffer, input ready);
    modport sink (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

### rtl/hrlq_out_if.sv
interface hrlq_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [1:0] field_tag;
    logic [7:0] data_byte;
    logic       value_bad;
    logic       no_value;
    logic       key_match;
    logic       request_status;
    logic       last_of_run;

    modport source (output valid, output out_kind, output field_tag, output data_byte,
                    output value_bad, output no_value, output key_match,
                    output request_status, output last_of_run, input ready);
    modport sink (input valid, input out_kind, input field_tag, input data_byte,
                  input value_bad, input no_value, input key_match,
                  input request_status, input last_of_run, output ready);
endinterface

### rtl/hrlq_cfg_if.sv
interface hrlq_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/hrlq_front.sv
module hrlq_front
(
    input  logic              clk,
    input  logic              rst_n,
    hrlq_in_if.sink           rx,
    hrlq_cfg_if.sink          cfg,
    input  hrlq_pkg::qstat_t  qstat,
    output logic              push,
    output hrlq_pkg::qent_t   push_ent
);

    typedef struct packed {
        hrlq_pkg::st_t  st;
        logic           vld;
        hrlq_pkg::res_t res;
    } step_t;

    localparam hrlq_pkg::st_t ST_RESET = '{
        phase:    hrlq_pkg::PH_METHOD,
        cr:       1'b0,
        esc:      hrlq_pkg::ESC_NONE,
        hi:       4'h0,
        inv:      1'b0,
        tok_eq:   1'b0,
        key_pos:  '0,
        key_diff: 1'b0,
        done:     1'b0
    };

    hrlq_pkg::st_t                      state_reg;
    hrlq_pkg::st_t                      state_next;
    logic [63:0]                        key_low_reg;
    logic [63:0]                        key_high_reg;
    logic [hrlq_pkg::KEY_LEN_W-1:0]     key_len_reg;
    logic                               accept;

    // {ok, value}
    function automatic logic [4:0] hex_val(logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= hrlq_pkg::CH_DIG0 && c <= hrlq_pkg::CH_DIG9)
            r = {1'b1, 4'(c - hrlq_pkg::CH_DIG0)};
        else if (c >= hrlq_pkg::CH_LOW_A && c <= hrlq_pkg::CH_LOW_F)
            r = {1'b1, 4'(c - hrlq_pkg::CH_LOW_A + 8'd10)};
        else if (c >= hrlq_pkg::CH_UP_A && c <= hrlq_pkg::CH_UP_F)
            r = {1'b1, 4'(c - hrlq_pkg::CH_UP_A + 8'd10)};
        return r;
    endfunction

    function automatic step_t line_byte(hrlq_pkg::st_t s, logic [7:0] c, logic [127:0] key,
                                        logic [hrlq_pkg::KEY_LEN_W-1:0] klen);
        step_t      r;
        logic [4:0] h;
        logic       kmatch;
        r = '0;
        r.st = s;
        h = hex_val(c);
        kmatch = (s.key_pos < hrlq_pkg::KEY_LEN_MAX) && (s.key_pos < klen)
                 && (key[{s.key_pos[3:0], 3'b000} +: 8] == c);
        unique case (s.phase)
            hrlq_pkg::PH_METHOD:
            begin
                r.vld = 1'b1;
                r.res.tag = hrlq_pkg::TAG_METHOD;
                if (c == hrlq_pkg::CH_SP)
                begin
                    r.res.kind = hrlq_pkg::KIND_END;
                    r.st.phase = hrlq_pkg::PH_PATH;
                end
                else
                begin
                    r.res.kind = hrlq_pkg::KIND_DATA;
                    r.res.data = c;
                end
            end
            hrlq_pkg::PH_PATH:
            begin
                r.vld = 1'b1;
                r.res.tag = hrlq_pkg::TAG_PATH;
                if (c == hrlq_pkg::CH_SP)
                begin
                    r.res.kind = hrlq_pkg::KIND_END;
                    r.st.phase = hrlq_pkg::PH_TAIL;
                end
                else if (c == hrlq_pkg::CH_QM)
                begin
                    r.res.kind = hrlq_pkg::KIND_END;
                    r.st.phase = hrlq_pkg::PH_QKEY;
                end
                else
                begin
                    r.res.kind = hrlq_pkg::KIND_DATA;
                    r.res.data = c;
                end
            end
            hrlq_pkg::PH_QKEY:
            begin
                r.vld = 1'b1;
                r.res.tag = hrlq_pkg::TAG_KEY;
                if (c == hrlq_pkg::CH_SP || c == hrlq_pkg::CH_AMP || c == hrlq_pkg::CH_EQ)
                begin
                    r.res.kind = hrlq_pkg::KIND_END;
                    r.res.nov = (c != hrlq_pkg::CH_EQ);
                    r.res.match = !s.key_diff && (s.key_pos == klen)
                                  && (klen <= hrlq_pkg::KEY_LEN_MAX);
                    r.st.key_pos = '0;
                    r.st.key_diff = 1'b0;
                    if (c == hrlq_pkg::CH_SP)
                        r.st.phase = hrlq_pkg::PH_TAIL;
                    else if (c == hrlq_pkg::CH_EQ)
                    begin
                        r.st.phase = hrlq_pkg::PH_QVAL;
                        r.st.tok_eq = 1'b1;
                    end
                end
                else
                begin
                    r.res.kind = hrlq_pkg::KIND_DATA;
                    r.res.data = c;
                    if (!kmatch)
                        r.st.key_diff = 1'b1;
                    if (s.key_pos != hrlq_pkg::KEY_POS_SAT)
                        r.st.key_pos = s.key_pos + 1'b1;
                end
            end
            hrlq_pkg::PH_QVAL:
            begin
                r.res.tag = hrlq_pkg::TAG_VALUE;
                if (c == hrlq_pkg::CH_SP || c == hrlq_pkg::CH_AMP)
                begin
                    r.vld = 1'b1;
                    r.res.kind = hrlq_pkg::KIND_END;
                    r.res.bad = s.inv || (s.esc != hrlq_pkg::ESC_NONE);
                    r.st.esc = hrlq_pkg::ESC_NONE;
                    r.st.hi = 4'h0;
                    r.st.inv = 1'b0;
                    r.st.tok_eq = 1'b0;
                    r.st.phase = (c == hrlq_pkg::CH_SP) ? hrlq_pkg::PH_TAIL
                                                        : hrlq_pkg::PH_QKEY;
                end
                else if (!s.inv)
                begin
                    r.res.kind = hrlq_pkg::KIND_DATA;
                    priority if (s.esc == hrlq_pkg::ESC_HIGH)
                    begin
                        if (!h[4])
                        begin
                            r.st.inv = 1'b1;
                            r.st.esc = hrlq_pkg::ESC_NONE;
                        end
                        else
                        begin
                            r.st.hi = h[3:0];
                            r.st.esc = hrlq_pkg::ESC_LOW;
                        end
                    end
                    else if (s.esc == hrlq_pkg::ESC_LOW)
                    begin
                        r.st.esc = hrlq_pkg::ESC_NONE;
                        if (!h[4])
                            r.st.inv = 1'b1;
                        else
                        begin
                            r.vld = 1'b1;
                            r.res.data = {s.hi, h[3:0]};
                        end
                    end
                    else if (c == hrlq_pkg::CH_PCT)
                        r.st.esc = hrlq_pkg::ESC_HIGH;
                    else
                    begin
                        r.vld = 1'b1;
                        r.res.data = (c == hrlq_pkg::CH_PLUS) ? hrlq_pkg::CH_SP : c;
                    end
                end
            end
            default:
            begin
                r.vld = 1'b0;
            end
        endcase
        return r;
    endfunction

    function automatic hrlq_pkg::res_t done_res(hrlq_pkg::st_t s);
        hrlq_pkg::res_t r;
        r = '0;
        r.kind = hrlq_pkg::KIND_DONE;
        r.tag = hrlq_pkg::TAG_METHOD;
        r.status = (s.phase != hrlq_pkg::PH_TAIL);
        return r;
    endfunction

    assign rx.ready  = !qstat.full;
    assign cfg.ready = 1'b1;
    assign accept    = rx.valid && rx.ready;

    always_comb
    begin
        hrlq_pkg::st_t s;
        step_t         t0;
        step_t         t1;
        step_t         t2;
        logic [127:0]  key;
        key = {key_high_reg, key_low_reg};
        s = state_reg;
        push_ent = '0;
        t0 = '0;
        t1 = '0;
        t2 = '0;
        if (!s.done)
        begin
            if (s.cr)
            begin
                s.cr = 1'b0;
                if (rx.in_byte == hrlq_pkg::CH_LF)
                begin
                    push_ent.mask[0] = 1'b1;
                    push_ent.res[0] = done_res(s);
                    s.done = 1'b1;
                end
                else
                begin
                    t0 = line_byte(s, hrlq_pkg::CH_CR, key, key_len_reg);
                    s = t0.st;
                    push_ent.mask[0] = t0.vld;
                    push_ent.res[0] = t0.res;
                    if (rx.in_byte == hrlq_pkg::CH_CR)
                        s.cr = 1'b1;
                    else
                    begin
                        t1 = line_byte(s, rx.in_byte, key, key_len_reg);
                        s = t1.st;
                        push_ent.mask[1] = t1.vld;
                        push_ent.res[1] = t1.res;
                    end
                end
            end
            else if (rx.in_byte == hrlq_pkg::CH_CR)
                s.cr = 1'b1;
            else
            begin
                t1 = line_byte(s, rx.in_byte, key, key_len_reg);
                s = t1.st;
                push_ent.mask[1] = t1.vld;
                push_ent.res[1] = t1.res;
            end
        end
        if (rx.end_of_buffer)
        begin
            if (!s.done)
            begin
                if (s.cr)
                begin
                    s.cr = 1'b0;
                    t2 = line_byte(s, hrlq_pkg::CH_CR, key, key_len_reg);
                    s = t2.st;
                    push_ent.mask[2] = t2.vld;
                    push_ent.res[2] = t2.res;
                end
                push_ent.mask[3] = 1'b1;
                push_ent.res[3] = done_res(s);
            end
            s = ST_RESET;
        end
        state_next = accept ? s : state_reg;
        push = accept && (push_ent.mask != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_RESET;
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    hrlq_pkg::REG_KEY_LOW:  key_low_reg  <= cfg.data;
                    hrlq_pkg::REG_KEY_HIGH: key_high_reg <= cfg.data;
                    hrlq_pkg::REG_KEY_LEN:  key_len_reg  <= cfg.data[hrlq_pkg::KEY_LEN_W-1:0];
                    default:
                    begin
                        key_len_reg <= key_len_reg;
                    end
                endcase
            end
        end
    end

endmodule

### rtl/hrlq_queue.sv
module hrlq_queue
#(
    parameter int DEPTH = hrlq_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hrlq_pkg::qent_t   push_ent,
    input  logic              pop,
    output hrlq_pkg::qent_t   head,
    output hrlq_pkg::qstat_t  qstat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    hrlq_pkg::qent_t    mem_reg [DEPTH];
    logic [PW-1:0]      wr_ptr_reg;
    logic [PW-1:0]      rd_ptr_reg;
    logic [CW-1:0]      count_reg;
    logic [PW-1:0]      wr_ptr_next;
    logic [PW-1:0]      rd_ptr_next;
    logic [CW-1:0]      count_next;
    logic               do_push;
    logic               do_pop;

    assign qstat.full  = (count_reg == CNT_FULL);
    assign qstat.empty = (count_reg == '0);
    assign head        = mem_reg[rd_ptr_reg];
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_ent;
    end

endmodule

### rtl/hrlq_back.sv
module hrlq_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  hrlq_pkg::qent_t   head,
    input  hrlq_pkg::qstat_t  qstat,
    output logic              pop,
    hrlq_out_if.source        fields
);

    hrlq_pkg::res_t [hrlq_pkg::SLOTS-1:0]  wk_res_reg;
    hrlq_pkg::res_t [hrlq_pkg::SLOTS-1:0]  wk_res_next;
    logic [hrlq_pkg::SLOTS-1:0]            wk_mask_reg;
    logic [hrlq_pkg::SLOTS-1:0]            wk_mask_next;
    logic                                  out_vld_reg;
    logic                                  out_vld_next;
    hrlq_pkg::res_t                        out_res_reg;
    hrlq_pkg::res_t                        out_res_next;
    logic                                  out_last_reg;
    logic                                  out_last_next;
    logic [hrlq_pkg::SLOT_W-1:0]           sel;
    logic [hrlq_pkg::SLOTS-1:0]            low_bit;
    logic [hrlq_pkg::SLOTS-1:0]            mask_after;
    logic                                  advance;
    logic                                  emit;

    always_comb
    begin
        sel = '0;
        for (int i = hrlq_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (wk_mask_reg[i])
                sel = hrlq_pkg::SLOT_W'(i);
        end
        low_bit    = wk_mask_reg & (~wk_mask_reg + 1'b1);
        mask_after = wk_mask_reg & ~low_bit;
        advance    = !out_vld_reg || fields.ready;
        emit       = advance && (wk_mask_reg != '0);
        // refill the work register in the same cycle its last result leaves
        pop        = !qstat.empty && ((wk_mask_reg == '0) || (emit && (mask_after == '0)));

        wk_res_next  = wk_res_reg;
        wk_mask_next = wk_mask_reg;
        if (pop)
        begin
            wk_res_next  = head.res;
            wk_mask_next = head.mask;
        end
        else if (emit)
            wk_mask_next = mask_after;

        out_res_next  = out_res_reg;
        out_last_next = out_last_reg;
        if (emit)
        begin
            out_vld_next  = 1'b1;
            out_res_next  = wk_res_reg[sel];
            out_last_next = (mask_after == '0);
        end
        else if (advance)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wk_mask_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            wk_mask_reg <= wk_mask_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wk_res_reg   <= wk_res_next;
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
    end

    assign fields.valid          = out_vld_reg;
    assign fields.out_kind       = out_res_reg.kind;
    assign fields.field_tag      = out_res_reg.tag;
    assign fields.data_byte      = out_res_reg.data;
    assign fields.value_bad      = out_res_reg.bad;
    assign fields.no_value       = out_res_reg.nov;
    assign fields.key_match      = out_res_reg.match;
    assign fields.request_status = out_res_reg.status;
    assign fields.last_of_run    = out_last_reg;

endmodule

### rtl/http_request_line_query_parser.sv
// Channel   Dir  Payload                                         Handshake
// rx        in   in_byte, end_of_buffer                          valid/ready
// fields    out  out_kind, field_tag, data_byte, value_bad,      valid/ready
//                no_value, key_match, request_status, last_of_run
// cfg       in   index, data (key low, key high, key length)     valid/ready
//
// The front parses one request byte per cycle while the result queue is not full, and
// queues its 0 to 3 results as one entry. The back sends one result beat per cycle while
// fields is ready, from a registered output stage, so the sustained rate is one byte per
// cycle while bytes give at most one result each; several results leave as separate beats.
// rx stalls only when the result queue is full; reset clears parse state and key registers.
module http_request_line_query_parser
#(
    parameter int QUEUE_DEPTH = hrlq_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    hrlq_in_if.sink      rx,
    hrlq_out_if.source   fields,
    hrlq_cfg_if.sink     cfg
);

    logic               push;
    logic               pop;
    hrlq_pkg::qent_t    push_ent;
    hrlq_pkg::qent_t    head;
    hrlq_pkg::qstat_t   qstat;

    hrlq_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .cfg      (cfg),
        .qstat    (qstat),
        .push     (push),
        .push_ent (push_ent)
    );

    hrlq_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_ent (push_ent),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    hrlq_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .qstat  (qstat),
        .pop    (pop),
        .fields (fields)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("push into full result queue");

    a_at_most_three: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !(&push_ent.mask))
        else $error("byte produced more than three results");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (fields.valid && fields.out_kind == hrlq_pkg::KIND_DONE) |-> fields.last_of_run)
        else $error("done beat not marked last of run");

    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty result queue");

endmodule
